// File: rtl/sws_pkg.sv
// ---------------------------------------------------------------------------
// sws_pkg
// shared constants, codes and controller/datapath handshake types for the
// sliding window sender
// ---------------------------------------------------------------------------
package sws_pkg;

    // default sizing, handed to the top level parameters
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int PENDING_CAP_DEF  = 256 * 1024;

    // fixed field widths
    localparam int SEQ_W   = 16;
    localparam int LEN_W   = 11;
    localparam int WL_W    = 7;
    localparam int THR_W   = 4;
    localparam int PEND_W  = 19;
    localparam int WIN_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;

    // results per event
    localparam int MAX_RESULTS = 64;
    localparam int RES_W       = 7;

    // duplicate ack counter saturation
    localparam logic [THR_W-1:0] DUP_MAX = 4'd15;

    // config register reset values
    localparam logic [WL_W-1:0]  WL_RESET   = 7'd64;
    localparam logic [LEN_W-1:0] MP_RESET   = 11'd1024;
    localparam logic [WIN_W-1:0] PEER_RESET = 16'd1;
    localparam logic [THR_W-1:0] THR_RESET  = 4'd3;

    // event codes carried in the input tuser
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_ACK    = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;

    typedef enum logic [CFG_A_W-1:0] {
        REG_WINDOW_LIMIT  = 2'd0,
        REG_MAX_PAYLOAD   = 2'd1,
        REG_INIT_PEER_WIN = 2'd2,
        REG_DUP_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_RETIRE,
        ST_DUP_RD,
        ST_DUP_EMIT,
        ST_TICK_RD,
        ST_TICK_EMIT,
        ST_CUT,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic add_bytes;
        logic ack_new;
        logic dup_update;
        logic peer_load;
        logic clr_acked;
        logic tick_setup;
        logic retire_step;
        logic rd_head;
        logic rd_tick;
        logic emit_rej;
        logic emit_dup;
        logic emit_tick;
        logic emit_cut;
        logic finish_push;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       pend_full;
        logic       ack_gt;
        logic       ack_eq;
        logic       dup_fire;
        logic       tick_go;
        logic       retire_ok;
        logic       tick_more;
        logic       cut_ok;
        logic       can_emit;
        logic       out_free;
        logic       stg_valid;
    } t_sts;

endpackage

// File: rtl/sliding_window_sender.sv
// ---------------------------------------------------------------------------
// sliding_window_sender
// sender window engine with fast retransmit, emits segment descriptors
// ---------------------------------------------------------------------------
// one event is taken at a time: s_axis_tready is high only while the
// sequencer is idle, and the sequencer returns to idle between events.
// an event passes through a dispatch step, then as its mode demands a
// retire walk that drops one segment per step plus a step that finds the
// end of the walk, resends that each take a registered read of the length
// ring (which sets their pace) and then emit, the cutting of new segments
// plus a step that finds the window or the pending bytes exhausted, and a
// closing step that releases the final result with tlast; stalls on the
// output side can hold any step that emits. the last result of an event
// may still sit in the output register while the next event is taken.
// the length ring needs no clearing pass after reset, since an entry is
// always written before it is read.
// ---------------------------------------------------------------------------
module sliding_window_sender
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
    parameter int PENDING_CAPACITY = PENDING_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    // event stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [47:0]        s_axis_tdata,  // byte_count, ack_number, advertised_window
    input  logic [1:0]         s_axis_tuser,  // mode
    // segment descriptor stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,  // segment_seq, segment_len, zero fill
    output logic [1:0]         m_axis_tuser,  // is_retransmit, rejected
    output logic               m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: picks the phase of each event and issues datapath commands
    sws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // window state, length ring, result stage and output register
    sws_dp #(
        .WINDOW_DEPTH     (WINDOW_DEPTH),
        .PENDING_CAPACITY (PENDING_CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_mode   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    // a new event never starts while a result of the previous one is staged
    a_idle_stage_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !sts.stg_valid
    ) else $error("event accepted with a staged result");

    // at most one result is produced per cycle
    a_one_emit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_rej, cmd.emit_dup, cmd.emit_tick, cmd.emit_cut})
    ) else $error("more than one result produced in a cycle");

    // a refused append is the only result of its event
    a_reject_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tlast && !m_axis_tuser[0])
    ) else $error("refused append not a lone final result");

    // a staged result only moves on when there is room downstream
    a_emit_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (cmd.finish_push || (sts.stg_valid && cmd.emit_cut)) |-> sts.out_free
    ) else $error("result pushed into an occupied output register");

endmodule

// File: rtl/sws_ram.sv
// ---------------------------------------------------------------------------
// sws_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module sws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sws_ctrl.sv
// ---------------------------------------------------------------------------
// sws_ctrl
// event sequencer: dispatch, retire, resend and segment cutting phases
// ---------------------------------------------------------------------------
module sws_ctrl
    import sws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority case (i_sts.mode)
                    MODE_APPEND: begin
                        if (i_sts.pend_full) begin
                            o_cmd.emit_rej = 1'b1;
                            n_state        = ST_FINISH;
                        end else begin
                            o_cmd.add_bytes = 1'b1;
                            n_state         = ST_CUT;
                        end
                    end
                    MODE_ACK: begin
                        o_cmd.peer_load = 1'b1;
                        if (i_sts.ack_gt) begin
                            o_cmd.ack_new = 1'b1;
                            n_state       = ST_RETIRE;
                        end else if (i_sts.ack_eq) begin
                            o_cmd.dup_update = 1'b1;
                            n_state = i_sts.dup_fire ? ST_DUP_RD : ST_CUT;
                        end else begin
                            n_state = ST_CUT;
                        end
                    end
                    MODE_TICK: begin
                        o_cmd.clr_acked = 1'b1;
                        if (i_sts.tick_go) begin
                            o_cmd.tick_setup = 1'b1;
                            n_state          = ST_TICK_RD;
                        end else begin
                            n_state = ST_CUT;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_RETIRE: begin
                if (i_sts.retire_ok) begin
                    o_cmd.retire_step = 1'b1;
                end else begin
                    n_state = ST_CUT;
                end
            end
            ST_DUP_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = ST_DUP_EMIT;
            end
            ST_DUP_EMIT: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_dup = 1'b1;
                    n_state        = ST_CUT;
                end
            end
            ST_TICK_RD: begin
                o_cmd.rd_tick = 1'b1;
                n_state       = ST_TICK_EMIT;
            end
            ST_TICK_EMIT: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_tick = 1'b1;
                    n_state = i_sts.tick_more ? ST_TICK_RD : ST_CUT;
                end
            end
            ST_CUT: begin
                if (!i_sts.cut_ok) begin
                    n_state = ST_FINISH;
                end else if (i_sts.can_emit) begin
                    o_cmd.emit_cut = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!i_sts.stg_valid) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.finish_push = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/sws_dp.sv
// ---------------------------------------------------------------------------
// sws_dp
// sender state, config registers, in-flight length ring, result stage and
// output register
// ---------------------------------------------------------------------------
module sws_dp
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH     = WINDOW_DEPTH_DEF,
    parameter int PENDING_CAPACITY = PENDING_CAP_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [1:0]         i_in_mode,
    input  logic [47:0]        i_in_data,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [31:0]        o_out_data,
    output logic [1:0]         o_out_user,
    output logic               o_out_last
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [PEND_W-1:0] PEND_CAP = PEND_W'(PENDING_CAPACITY);
    localparam logic [RES_W-1:0]  RES_MAX = RES_W'(MAX_RESULTS);

    // config
    logic [WL_W-1:0]   r_wl;
    logic [LEN_W-1:0]  r_mp;
    logic [THR_W-1:0]  r_thr;

    // sender state
    logic [WIN_W-1:0]  r_peer;
    logic [SEQ_W-1:0]  r_next_seq;
    logic [SEQ_W-1:0]  r_last_ack;
    logic [THR_W-1:0]  r_dup_cnt;
    logic              r_acked;
    logic [PEND_W-1:0] r_pend;
    logic [CNT_W-1:0]  r_infl;
    logic [IDX_W-1:0]  r_head;
    logic [IDX_W-1:0]  r_tail;

    // per event working registers
    logic [1:0]        r_mode;
    logic [15:0]       r_bytes;
    logic [SEQ_W-1:0]  r_ack;
    logic [WIN_W-1:0]  r_adv;
    logic [RES_W-1:0]  r_n;
    logic [IDX_W-1:0]  r_rd_ptr;
    logic [SEQ_W-1:0]  r_tick_seq;
    logic [CNT_W-1:0]  r_tick_idx;

    // result stage and output register
    logic              r_stg_valid;
    logic [SEQ_W-1:0]  r_stg_seq;
    logic [LEN_W-1:0]  r_stg_len;
    logic              r_stg_retx;
    logic              r_stg_rej;
    logic              r_out_valid;
    logic [SEQ_W-1:0]  r_out_seq;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_retx;
    logic              r_out_rej;
    logic              r_out_last;

    logic [SEQ_W-1:0]  front_seq;
    logic              win_ok;
    logic [LEN_W-1:0]  cut_len;
    logic [THR_W-1:0]  dup_inc;
    logic [PEND_W:0]   pend_sum;
    logic              out_free;
    logic              emit_any;
    logic [SEQ_W-1:0]  n_res_seq;
    logic [LEN_W-1:0]  n_res_len;
    logic              n_res_retx;
    logic              n_res_rej;
    logic [LEN_W-1:0]  ram_rdata;
    logic [IDX_W-1:0]  ram_raddr;

    assign front_seq = r_next_seq - SEQ_W'(r_infl);
    assign win_ok = (SEQ_W'(r_infl) < SEQ_W'(r_wl)) && (r_infl < DEPTH_CNT)
                    && (SEQ_W'(r_infl) < r_peer);
    assign cut_len = (r_pend < PEND_W'(r_mp)) ? r_pend[LEN_W-1:0] : r_mp;
    assign dup_inc = (r_dup_cnt == DUP_MAX) ? r_dup_cnt : r_dup_cnt + 1'b1;
    assign pend_sum = {1'b0, r_pend} + (PEND_W + 1)'(r_bytes);
    assign out_free = !r_out_valid || i_out_ready;
    assign emit_any = i_cmd.emit_rej | i_cmd.emit_dup | i_cmd.emit_tick | i_cmd.emit_cut;

    always_comb begin
        o_sts           = '0;
        o_sts.mode      = r_mode;
        o_sts.pend_full = r_pend >= PEND_CAP;
        o_sts.ack_gt    = r_ack > r_last_ack;
        o_sts.ack_eq    = r_ack == r_last_ack;
        o_sts.dup_fire  = (dup_inc >= r_thr) && (r_infl != '0);
        o_sts.tick_go   = (r_infl != '0) && !r_acked;
        o_sts.retire_ok = (r_infl != '0) && (front_seq < r_ack);
        o_sts.tick_more = (({1'b0, r_tick_idx} + 1'b1) < {1'b0, r_infl})
                          && (({1'b0, r_n} + 1'b1) < {1'b0, RES_MAX});
        o_sts.cut_ok    = win_ok && (r_pend != '0) && (r_mp != '0) && (r_n < RES_MAX);
        o_sts.can_emit  = !r_stg_valid || out_free;
        o_sts.out_free  = out_free;
        o_sts.stg_valid = r_stg_valid;
    end

    // value of the result produced this cycle
    always_comb begin
        n_res_seq  = r_next_seq;
        n_res_len  = cut_len;
        n_res_retx = 1'b0;
        n_res_rej  = 1'b0;
        priority if (i_cmd.emit_rej) begin
            n_res_seq = '0;
            n_res_len = '0;
            n_res_rej = 1'b1;
        end else if (i_cmd.emit_dup) begin
            n_res_seq  = front_seq;
            n_res_len  = ram_rdata;
            n_res_retx = 1'b1;
        end else if (i_cmd.emit_tick) begin
            n_res_seq  = r_tick_seq;
            n_res_len  = ram_rdata;
            n_res_retx = 1'b1;
        end else begin
            n_res_seq = r_next_seq;
        end
    end

    assign ram_raddr = i_cmd.rd_tick ? r_rd_ptr : r_head;

    sws_ram #(
        .WIDTH (LEN_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.emit_cut),
        .i_waddr (r_tail),
        .i_wdata (cut_len),
        .i_re    (i_cmd.rd_head | i_cmd.rd_tick),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // config and sender state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl        <= WL_RESET;
            r_mp        <= MP_RESET;
            r_thr       <= THR_RESET;
            r_peer      <= PEER_RESET;
            r_next_seq  <= '0;
            r_last_ack  <= '0;
            r_dup_cnt   <= '0;
            r_acked     <= 1'b0;
            r_pend      <= '0;
            r_infl      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_WINDOW_LIMIT:  r_wl  <= i_cfg_wdata[WL_W-1:0];
                    REG_MAX_PAYLOAD:   r_mp  <= i_cfg_wdata[LEN_W-1:0];
                    REG_INIT_PEER_WIN: begin
                        // a zero peer window from the handshake reads as one
                        r_peer <= (i_cfg_wdata == '0) ? PEER_RESET : i_cfg_wdata;
                    end
                    REG_DUP_THRESHOLD: r_thr <= i_cfg_wdata[THR_W-1:0];
                endcase
            end
            if (i_cmd.latch_in) begin
                r_n <= '0;
            end else if (emit_any) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.add_bytes) begin
                r_pend <= pend_sum[PEND_W] ? '1 : pend_sum[PEND_W-1:0];
            end
            if (i_cmd.peer_load) begin
                r_peer <= r_adv;
            end
            if (i_cmd.ack_new) begin
                r_last_ack <= r_ack;
                r_dup_cnt  <= '0;
                r_acked    <= 1'b1;
            end
            if (i_cmd.dup_update) begin
                r_dup_cnt <= o_sts.dup_fire ? '0 : dup_inc;
            end
            if (i_cmd.clr_acked) begin
                r_acked <= 1'b0;
            end
            if (i_cmd.retire_step) begin
                r_head <= (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
                r_infl <= r_infl - 1'b1;
            end
            if (i_cmd.emit_cut) begin
                r_tail     <= (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
                r_infl     <= r_infl + 1'b1;
                r_pend     <= r_pend - PEND_W'(cut_len);
                r_next_seq <= r_next_seq + 1'b1;
            end
        end
    end

    // latched event fields and resend walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mode  <= i_in_mode;
            r_bytes <= i_in_data[15:0];
            r_ack   <= i_in_data[31:16];
            r_adv   <= i_in_data[47:32];
        end
        if (i_cmd.tick_setup) begin
            r_rd_ptr   <= r_head;
            r_tick_seq <= front_seq;
            r_tick_idx <= '0;
        end else if (i_cmd.emit_tick) begin
            r_rd_ptr   <= (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
            r_tick_seq <= r_tick_seq + 1'b1;
            r_tick_idx <= r_tick_idx + 1'b1;
        end
    end

    // result stage holds one result until it is known whether another follows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_any) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd.finish_push) begin
                r_stg_valid <= 1'b0;
            end
            if (i_cmd.finish_push || (emit_any && r_stg_valid)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_stg_seq  <= n_res_seq;
            r_stg_len  <= n_res_len;
            r_stg_retx <= n_res_retx;
            r_stg_rej  <= n_res_rej;
        end
        if (i_cmd.finish_push || (emit_any && r_stg_valid)) begin
            r_out_seq  <= r_stg_seq;
            r_out_len  <= r_stg_len;
            r_out_retx <= r_stg_retx;
            r_out_rej  <= r_stg_rej;
            r_out_last <= i_cmd.finish_push;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {5'b0, r_out_len, r_out_seq};
    assign o_out_user  = {r_out_rej, r_out_retx};
    assign o_out_last  = r_out_last;

endmodule

// File: tb/sliding_window_sender_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sliding_window_sender_test
// self-checking bench for the sliding window sender: a directed table of
// events and register writes, then phases of random traffic under several
// window settings, every descriptor checked against the table or a local window model
// ---------------------------------------------------------------------------
module sliding_window_sender_test;
    import sws_pkg::*;

    // unused event code, the block must drop it silently
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int RING_DEPTH  = WINDOW_DEPTH_DEF;
    localparam int PEND_SAT    = (1 << PEND_W) - 1;
    // a full window of resends must fit in the settle time, leave room on top
    localparam int SETTLE_CYC  = 200;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 30;

    // one segment descriptor as seen on the output stream
    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        logic             retx;
        logic             rej;
        logic             last;
    } t_seg_desc;

    // directed step: a register write or an event; typed_n of -1 leaves the
    // expectation to the window model, 0 or 1 gives it here (last implied)
    typedef struct {
        bit               is_cfg;
        t_reg_idx         reg_idx;
        logic [CFG_W-1:0] reg_val;
        logic [1:0]       mode;
        logic [15:0]      bytes;
        logic [15:0]      ack;
        logic [15:0]      adv;
        int               typed_n;
        logic [SEQ_W-1:0] t_seq;
        logic [LEN_W-1:0] t_len;
        logic             t_retx;
        logic             t_rej;
    } t_dir_step;

    localparam int N_DIR = 24;

    t_dir_step dir_tab [N_DIR] = '{
        // first append after reset, peer window of one lets one segment out
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'd100, 16'd0, 16'd0, 1, 16'd0, 11'd100, 0, 0},
        // unused code, nothing comes back
        '{0, REG_WINDOW_LIMIT, 0, MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0},
        // duplicate ack closing the peer window
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        // fill the pending buffer past capacity while the window is shut
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 0, 0, 0, 0, 0},
        // buffer full: refused
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'hFFFF, 16'd0, 16'd0, 1, 16'd0, 11'd0, 0, 1},
        // window opens wide: the rest of a full window is cut at once
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd0, 16'hFFFF, -1, 0, 0, 0, 0},
        // no ack since the last tick: whole window resent
        '{0, REG_WINDOW_LIMIT, 0, MODE_TICK, 16'd0, 16'd0, 16'd0, -1, 0, 0, 0, 0},
        // third duplicate: fast retransmit of the oldest
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd0, 16'hFFFF, -1, 0, 0, 0, 0},
        // ack retires the whole window, a fresh window follows
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd64, 16'd64, -1, 0, 0, 0, 0},
        // acked since the last tick: no resend
        '{0, REG_WINDOW_LIMIT, 0, MODE_TICK, 16'd0, 16'd0, 16'd0, -1, 0, 0, 0, 0},
        // threshold of zero fires on every duplicate
        '{1, REG_DUP_THRESHOLD, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd64, 16'd64, -1, 0, 0, 0, 0},
        // stale ack only moves the peer window
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd3, 16'd5, -1, 0, 0, 0, 0},
        '{1, REG_WINDOW_LIMIT, 16'd3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_MAX_PAYLOAD, 16'd2047, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // zero written as the handshake window loads one
        '{1, REG_INIT_PEER_WIN, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, REG_DUP_THRESHOLD, 16'd15, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        // partial retire, window still over the limit
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd70, 16'd9, -1, 0, 0, 0, 0},
        // full retire, three largest segments cut
        '{0, REG_WINDOW_LIMIT, 0, MODE_ACK, 16'd0, 16'd128, 16'd9, -1, 0, 0, 0, 0},
        '{0, REG_WINDOW_LIMIT, 0, MODE_APPEND, 16'd1, 16'd0, 16'd0, -1, 0, 0, 0, 0}
    };

    // register settings per random phase, extremes included
    int wl_plan  [N_PHASES] = '{64, 1, 127, 8, 0, 33, 64, 2, 16, 100};
    int mp_plan  [N_PHASES] = '{1, 2047, 100, 0, 512, 1, 2047, 700, 64, 1024};
    int ipw_plan [N_PHASES] = '{65535, 1, 0, 20, 65535, 3, 64, 1, 40, 65535};
    int thr_plan [N_PHASES] = '{1, 15, 0, 3, 2, 1, 15, 4, 0, 3};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [47:0]        s_axis_tdata;   // byte_count, ack_number, advertised_window
    logic [1:0]         s_axis_tuser;   // mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b1;
    logic [31:0]        m_axis_tdata;   // segment_seq, segment_len, zero fill
    logic [1:0]         m_axis_tuser;   // is_retransmit, rejected
    logic               m_axis_tlast;

    sliding_window_sender u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // window model: register copies and sender state
    // -----------------------------------------------------------------------
    int unsigned      cwnd_lim;
    int unsigned      seg_max;
    int unsigned      dup_thr;
    logic [SEQ_W-1:0] snd_next;
    logic [SEQ_W-1:0] una_ack;
    int unsigned      dups;
    bit               ack_seen;
    int unsigned      peer_win;
    int unsigned      queued_bytes;
    int unsigned      flight_n;
    int unsigned      ring_head;
    logic [LEN_W-1:0] flight_len [RING_DEPTH];

    t_seg_desc seg_new [$];   // descriptors caused by the event being modeled
    t_seg_desc seg_due [$];   // descriptors still owed by the block

    // run bookkeeping
    int  err_cnt      = 0;
    int  event_cnt    = 0;
    int  seg_cnt      = 0;
    int  resend_cnt   = 0;
    int  refused_cnt  = 0;
    int  setting_cnt  = 0;
    bit  calm         = 1'b0;
    int  tx_gap_pct   = 0;
    int  rx_stall_pct = 0;
    int  rx_stall_left = 0;

    function automatic int unsigned usable_window();
        int unsigned w;
        w = (cwnd_lim > RING_DEPTH) ? RING_DEPTH : cwnd_lim;
        return (w < peer_win) ? w : peer_win;
    endfunction

    function automatic logic [SEQ_W-1:0] oldest_seq();
        return snd_next - flight_n[SEQ_W-1:0];
    endfunction

    task automatic add_desc(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                            input logic retx, input logic rej);
        t_seg_desc d;
        d.seq  = seq;
        d.len  = len;
        d.retx = retx;
        d.rej  = rej;
        d.last = 1'b0;
        seg_new.insert(seg_new.size(), d);
    endtask

    // cut fresh segments from the pending bytes while the window has room
    task automatic cut_fresh();
        int unsigned len;
        while (flight_n < usable_window() && queued_bytes > 0 && seg_max > 0 &&
               seg_new.size() < MAX_RESULTS) begin
            len = (queued_bytes < seg_max) ? queued_bytes : seg_max;
            flight_len[(ring_head + flight_n) % RING_DEPTH] = len[LEN_W-1:0];
            flight_n++;
            queued_bytes -= len;
            add_desc(snd_next, len[LEN_W-1:0], 1'b0, 1'b0);
            snd_next = snd_next + 1'b1;
        end
    endtask

    // advance the window model by one event, leaving its descriptors in seg_new
    task automatic advance_sender(input logic [1:0] mode, input logic [15:0] bytes,
                                  input logic [15:0] ack, input logic [15:0] adv);
        logic [SEQ_W-1:0] base;
        seg_new.delete();
        case (mode)
            MODE_APPEND: begin
                if (queued_bytes >= PENDING_CAP_DEF) begin
                    add_desc('0, '0, 1'b0, 1'b1);
                end else begin
                    queued_bytes += bytes;
                    if (queued_bytes > PEND_SAT) queued_bytes = PEND_SAT;
                    cut_fresh();
                end
            end
            MODE_ACK: begin
                if (ack > una_ack) begin
                    // cumulative ack: retire everything below it
                    while (flight_n > 0 && oldest_seq() < ack) begin
                        ring_head = (ring_head + 1) % RING_DEPTH;
                        flight_n--;
                    end
                    una_ack  = ack;
                    dups     = 0;
                    ack_seen = 1'b1;
                end else if (ack == una_ack) begin
                    if (dups < DUP_MAX) dups++;
                    if (dups >= dup_thr && flight_n > 0) begin
                        add_desc(oldest_seq(), flight_len[ring_head], 1'b1, 1'b0);
                        dups = 0;
                    end
                end
                peer_win = adv;
                cut_fresh();
            end
            MODE_TICK: begin
                if (flight_n > 0 && !ack_seen) begin
                    base = oldest_seq();
                    for (int i = 0; i < flight_n && seg_new.size() < MAX_RESULTS; i++)
                        add_desc(base + i[SEQ_W-1:0],
                                 flight_len[(ring_head + i) % RING_DEPTH], 1'b1, 1'b0);
                end
                ack_seen = 1'b0;
                cut_fresh();
            end
            default: ;
        endcase
        if (seg_new.size() > 0) seg_new[seg_new.size() - 1].last = 1'b1;
    endtask

    // -----------------------------------------------------------------------
    // stimulus side
    // -----------------------------------------------------------------------

    // register write, only ever issued with the block idle
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_WINDOW_LIMIT:  cwnd_lim = val[WL_W-1:0];
            REG_MAX_PAYLOAD:   seg_max  = val[LEN_W-1:0];
            REG_INIT_PEER_WIN: peer_win = (val == 0) ? 1 : val;
            REG_DUP_THRESHOLD: dup_thr  = val[THR_W-1:0];
            default: ;
        endcase
        setting_cnt++;
    endtask

    // stop sending and wait until every owed descriptor has come out, then
    // give an event with no descriptors time to finish inside the block
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (seg_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // one event transfer; typed_n < 0 hands the expectation to the model
    task automatic send_event(input logic [1:0] mode, input logic [15:0] bytes,
                              input logic [15:0] ack, input logic [15:0] adv,
                              input int typed_n, input t_seg_desc typed_res);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {adv, ack, bytes};
        do @(posedge i_clk); while (!s_axis_tready);
        advance_sender(mode, bytes, ack, adv);
        if (typed_n < 0) begin
            foreach (seg_new[k]) seg_due.insert(seg_due.size(), seg_new[k]);
        end else if (typed_n == 1) begin
            seg_due.insert(seg_due.size(), typed_res);
        end
        event_cnt++;
        // sender gap burst
        if (!calm && $urandom_range(0, 99) < tx_gap_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // random event: mostly well-formed acks inside the flight, duplicates,
    // appends and ticks; a little noise with stale acks and the unused code
    task automatic pick_event(output logic [1:0] mode, output logic [15:0] bytes,
                              output logic [15:0] ack, output logic [15:0] adv);
        int unsigned r;
        int unsigned hi;
        r     = $urandom_range(0, 99);
        bytes = 16'($urandom());
        ack   = 16'($urandom());
        case ($urandom_range(0, 9))
            0:       adv = 16'd0;
            1:       adv = 16'hFFFF;
            2:       adv = 16'($urandom());
            default: adv = 16'($urandom_range(1, 70));
        endcase
        if (r < 35) begin
            mode = MODE_APPEND;
            case ($urandom_range(0, 9))
                0:          bytes = 16'hFFFF;
                1:          bytes = 16'd0;
                2, 3, 4:    bytes = 16'($urandom());
                default:    bytes = 16'($urandom_range(1, 3000));
            endcase
        end else if (r < 65) begin
            mode = MODE_ACK;
            hi   = int'(snd_next) + 2;
            if (hi <= una_ack) hi = int'(una_ack) + 1;
            if (hi > 65534) hi = 65534;
            ack  = (una_ack >= hi) ? una_ack
                                   : 16'($urandom_range(int'(una_ack) + 1, hi));
        end else if (r < 80) begin
            mode = MODE_ACK;
            ack  = una_ack;
        end else if (r < 84) begin
            mode = MODE_ACK;
            ack  = (una_ack == 0) ? 16'd0 : 16'($urandom_range(0, int'(una_ack) - 1));
        end else if (r < 97) begin
            mode = MODE_TICK;
        end else begin
            mode = MODE_UNUSED;
        end
    endtask

    // -----------------------------------------------------------------------
    // receive side: stall bursts on tready, changed at the falling edge
    // -----------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < rx_stall_pct) begin
            rx_stall_left <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // every output transfer against the oldest owed descriptor
    always @(posedge i_clk) begin : desc_check
        t_seg_desc want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (seg_due.size() == 0) begin
                $error("unexpected descriptor: seq %0d len %0d", m_axis_tdata[15:0],
                       m_axis_tdata[26:16]);
                err_cnt++;
            end else begin
                want = seg_due[0];
                seg_due.delete(0);
                check_field("segment_seq", want.seq, m_axis_tdata[15:0]);
                check_field("segment_len", want.len, m_axis_tdata[26:16]);
                check_field("is_retransmit", want.retx, m_axis_tuser[0]);
                check_field("rejected", want.rej, m_axis_tuser[1]);
                check_field("last", want.last, m_axis_tlast);
            end
            seg_cnt++;
            if (m_axis_tuser[0]) resend_cnt++;
            if (m_axis_tuser[1]) refused_cnt++;
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin : main_seq
        t_seg_desc   typed;
        logic [1:0]  mode;
        logic [15:0] bytes;
        logic [15:0] ack;
        logic [15:0] adv;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = '0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;

        // model state after reset
        cwnd_lim     = WL_RESET;
        seg_max      = MP_RESET;
        dup_thr      = THR_RESET;
        peer_win     = PEER_RESET;
        snd_next     = '0;
        una_ack      = '0;
        dups         = 0;
        ack_seen     = 1'b0;
        queued_bytes = 0;
        flight_n     = 0;
        ring_head    = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, receiver and sender busy at random
        tx_gap_pct   = 25;
        rx_stall_pct = 30;
        foreach (dir_tab[s]) begin
            if (dir_tab[s].is_cfg) begin
                settle();
                write_reg(dir_tab[s].reg_idx, dir_tab[s].reg_val);
            end else begin
                typed.seq  = dir_tab[s].t_seq;
                typed.len  = dir_tab[s].t_len;
                typed.retx = dir_tab[s].t_retx;
                typed.rej  = dir_tab[s].t_rej;
                typed.last = 1'b1;
                send_event(dir_tab[s].mode, dir_tab[s].bytes, dir_tab[s].ack,
                           dir_tab[s].adv, dir_tab[s].typed_n, typed);
            end
        end

        // random phases, each behind a full drain and a new register setting
        for (int p = 0; p < N_PHASES; p++) begin
            // the last phase is calm, so no stall may reach into it
            calm = (p == N_PHASES - 1);
            settle();
            write_reg(REG_WINDOW_LIMIT, CFG_W'(wl_plan[p]));
            write_reg(REG_MAX_PAYLOAD, CFG_W'(mp_plan[p]));
            write_reg(REG_INIT_PEER_WIN, CFG_W'(ipw_plan[p]));
            write_reg(REG_DUP_THRESHOLD, CFG_W'(thr_plan[p]));
            // some phases keep one side or both free of idling
            tx_gap_pct   = (p % 3 == 1) ? 0 : 25;
            rx_stall_pct = (p % 3 == 2) ? 0 : 30;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick_event(mode, bytes, ack, adv);
                // close with the top ack value: it freezes retiring, so it
                // only comes once nothing else is left to explore
                if (p == N_PHASES - 1 && k == PHASE_ITEMS - 3) begin
                    mode = MODE_ACK;
                    ack  = 16'hFFFF;
                end
                send_event(mode, bytes, ack, adv, -1, typed);
            end
        end

        settle();
        $display("ran %0d events through %0d register writes", event_cnt, setting_cnt);
        $display("saw %0d descriptors: %0d resends, %0d refused appends",
                 seg_cnt, resend_cnt, refused_cnt);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/sws_pkg.sv
rtl/sws_ram.sv
rtl/sws_ctrl.sv
rtl/sws_dp.sv
rtl/sliding_window_sender.sv
tb/sliding_window_sender_test.sv
